### hdl/klx_pkg.sv
`default_nettype none

package klx_pkg;

  // defaults for the top level parameters
  localparam int unsigned KLX_MAX_BYTES   = 262144;
  localparam int unsigned KLX_TOKEN_LIMIT = 4096;
  localparam int unsigned KLX_FIFO_DEPTH  = 4;

  // result field widths
  localparam int unsigned KIND_W = 5;
  localparam int unsigned TOK_W  = 19;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_STRING   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_KW_FIRST = 5'd3;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_COLON    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd16;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_DOT      = 5'd18;
  localparam logic [KIND_W-1:0] KIND_EQUALS   = 5'd19;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd20;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_UNTERM   = 5'd22;
  localparam logic [KIND_W-1:0] KIND_END      = 5'd23;

  // scanner state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  // keyword table, kind is KIND_KW_FIRST plus the row
  localparam int unsigned KW_NUM     = 10;
  localparam int unsigned KW_MAX_LEN = 9;
  localparam int unsigned KW_CNT_W   = 4;

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
    '{"s", "e", "c", "t", "i", "o", "n", 8'h00, 8'h00},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n", 8'h00},
    '{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00, 8'h00},
    '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "o", "c", "e", "d", "u", "r", "e"}
  };

  localparam logic [KW_CNT_W-1:0] KW_LEN [KW_NUM] = '{
    4'd7, 4'd3, 4'd8, 4'd5, 4'd2, 4'd6, 4'd4, 4'd2, 4'd2, 4'd9
  };

  // one token as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  start;
    logic [TOK_W-1:0]  len;
    logic [TOK_W-1:0]  line;
    logic [TOK_W-1:0]  col;
  } tok_t;

  // all tokens caused by one byte
  typedef struct packed {
    logic [1:0]     count;
    tok_t [2:0]     slot;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    case (c) inside
      [8'h41:8'h5A], [8'h61:8'h7A]: return 1'b1;
      default:                      return 1'b0;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    case (c) inside
      [8'h30:8'h39]: return 1'b1;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == 8'h5F);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    case (c) inside
      [8'h09:8'h0D], 8'h20, 8'hA0: return 1'b1;
      default:                     return 1'b0;
    endcase
  endfunction

  // zero for a byte that is no punctuation mark
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h2C:   return KIND_COMMA;
      8'h3A:   return KIND_COLON;
      8'h3B:   return KIND_SEMI;
      8'h28:   return KIND_LPAREN;
      8'h29:   return KIND_RPAREN;
      8'h2E:   return KIND_DOT;
      8'h3D:   return KIND_EQUALS;
      8'h2B:   return KIND_PLUS;
      8'h2D:   return KIND_MINUS;
      default: return '0;
    endcase
  endfunction

  // drop every keyword that the character at position cnt rules out
  function automatic logic [KW_NUM-1:0] kw_update(input logic [KW_NUM-1:0]   hits,
                                                  input logic [KW_CNT_W-1:0] cnt,
                                                  input logic [7:0]          c);
    logic [KW_NUM-1:0]   res;
    logic [KW_CNT_W-1:0] idx;
    logic                ok;
    res = hits;
    idx = (cnt < KW_CNT_W'(KW_MAX_LEN)) ? cnt : '0;
    for (int k = 0; k < KW_NUM; k++) begin
      ok = (cnt < KW_LEN[k]) && ((c & 8'hDF) == (KW_TEXT[k][idx] & 8'hDF));
      if (!ok) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_NUM-1:0]   hits,
                                                   input logic [KW_CNT_W-1:0] cnt);
    logic [KIND_W-1:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (hits[k] && (cnt == KW_LEN[k])) begin
        kind = KIND_KW_FIRST + KIND_W'(k);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

### hdl/keyword_lexer_stream.sv
// path: a byte's tokens pass through the queue and then the token sequencer's output register to the out_ ports
// throughput: one byte per cycle in while full is low and one token per cycle out while pop is held;
//   the front scans every byte combinationally, the back hands out the tokens of a word in order,
//   and full rises once the four-word queue between them fills
// reset: rst_n low at a rising edge clears scan state, position, token count and the queue;
//   the block accepts bytes in the first cycle after reset
`default_nettype none

module keyword_lexer_stream #(
  parameter int unsigned MAX_BYTES   = klx_pkg::KLX_MAX_BYTES,
  parameter int unsigned TOKEN_LIMIT = klx_pkg::KLX_TOKEN_LIMIT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // byte side
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  in_text_byte,
  input  wire logic                        in_is_final,
  // token side
  output logic                             empty,
  input  wire logic                        pop,
  output logic [klx_pkg::KIND_W-1:0]       out_token_kind,
  output logic [klx_pkg::TOK_W-1:0]        out_token_start,
  output logic [klx_pkg::TOK_W-1:0]        out_token_length,
  output logic [klx_pkg::TOK_W-1:0]        out_token_line,
  output logic [klx_pkg::TOK_W-1:0]        out_token_column,
  output logic                             out_run_end
);

  import klx_pkg::*;

  localparam int unsigned BND_W = $bits(bundle_t);

  // front side: one byte per cycle, taken whenever the queue has room
  logic    byte_acc;
  logic    bnd_vld;
  bundle_t bnd;

  // queue between the scanner and the token sequencer
  bundle_t q_data;
  logic    q_empty, q_pop;
  tok_t    tok;

  assign byte_acc = push && !full;

  // scanner: classifies the byte, tracks position and emits a word of up to three tokens
  klx_front #(
    .MAX_BYTES   (MAX_BYTES),
    .TOKEN_LIMIT (TOKEN_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_acc),
    .text_byte (in_text_byte),
    .is_final  (in_is_final),
    .bnd_vld   (bnd_vld),
    .bnd       (bnd)
  );

  // only bytes that cause tokens take a queue entry
  klx_fifo #(
    .WIDTH (BND_W),
    .DEPTH (KLX_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bnd_vld),
    .wr_data (bnd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  // token sequencer: holds one word in its output register and hands out its tokens in order
  klx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .tok     (tok),
    .run_end (out_run_end)
  );

  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.len;
  assign out_token_line   = tok.line;
  assign out_token_column = tok.col;

endmodule

`default_nettype wire

### hdl/klx_front.sv
`default_nettype none

module klx_front #(
  parameter int unsigned MAX_BYTES   = klx_pkg::KLX_MAX_BYTES,
  parameter int unsigned TOKEN_LIMIT = klx_pkg::KLX_TOKEN_LIMIT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_vld,
  input  wire logic [7:0]       text_byte,
  input  wire logic             is_final,
  output logic                  bnd_vld,
  output klx_pkg::bundle_t      bnd
);

  import klx_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BYTES + 2);
  localparam int unsigned CNT_W = $clog2(TOKEN_LIMIT + 1);
  localparam int unsigned LIM_W = CNT_W + 2;

  mode_t              mode_r, mode_nxt, mode_mid;
  logic               quote_dbl_r, quote_dbl_nxt;
  logic [POS_W-1:0]   off_r, off_nxt;
  logic [POS_W-1:0]   line_r, line_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   tstart_r, tstart_nxt;
  logic [POS_W-1:0]   tline_r, tline_nxt;
  logic [POS_W-1:0]   tcol_r, tcol_nxt;
  logic [KW_NUM-1:0]  hits_r, hits_nxt;
  logic [KW_CNT_W-1:0] kwcnt_r, kwcnt_nxt;
  logic [CNT_W-1:0]   emitted_r, emitted_nxt;
  logic               ended_r, ended_nxt;

  logic               eoi, term;
  logic [7:0]         quote_c;
  logic               cand_v [4];
  tok_t               cand   [4];
  tok_t [2:0]         slot;
  logic [1:0]         n, take;
  logic [LIM_W-1:0]   room;

  function automatic tok_t finish_tok(input mode_t               mode,
                                      input logic [KW_NUM-1:0]   hits,
                                      input logic [KW_CNT_W-1:0] cnt,
                                      input logic [POS_W-1:0]    tstart,
                                      input logic [POS_W-1:0]    tline,
                                      input logic [POS_W-1:0]    tcol,
                                      input logic [POS_W-1:0]    off);
    tok_t t;
    case (mode)
      MODE_IDENT:  t.kind = ident_kind(hits, cnt);
      MODE_NUMBER: t.kind = KIND_NUMBER;
      default:     t.kind = KIND_UNTERM;
    endcase
    t.start = TOK_W'(tstart);
    t.len   = TOK_W'(off - tstart);
    t.line  = TOK_W'(tline);
    t.col   = TOK_W'(tcol);
    return t;
  endfunction

  function automatic tok_t end_tok(input logic [POS_W-1:0] off,
                                   input logic [POS_W-1:0] line,
                                   input logic [POS_W-1:0] col);
    tok_t t;
    t.kind  = KIND_END;
    t.start = TOK_W'(off);
    t.len   = '0;
    t.line  = TOK_W'(line);
    t.col   = TOK_W'(col);
    return t;
  endfunction

  assign eoi     = (text_byte == 8'h00) || (off_r >= POS_W'(MAX_BYTES));
  assign quote_c = quote_dbl_r ? 8'h22 : 8'h27;

  always_comb begin
    mode_nxt      = mode_r;
    quote_dbl_nxt = quote_dbl_r;
    off_nxt       = off_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    tstart_nxt    = tstart_r;
    tline_nxt     = tline_r;
    tcol_nxt      = tcol_r;
    hits_nxt      = hits_r;
    kwcnt_nxt     = kwcnt_r;
    ended_nxt     = ended_r;
    term          = 1'b0;
    mode_mid      = mode_r;
    for (int j = 0; j < 4; j++) begin
      cand_v[j] = 1'b0;
      cand[j]   = '0;
    end

    if (byte_vld && !ended_r) begin
      if (eoi) begin
        cand_v[0] = (mode_r != MODE_IDLE);
        cand[0]   = finish_tok(mode_r, hits_r, kwcnt_r, tstart_r, tline_r, tcol_r, off_r);
        cand_v[3] = 1'b1;
        cand[3]   = end_tok(off_r, line_r, col_r);
        mode_nxt  = MODE_IDLE;
        ended_nxt = 1'b1;
      end else begin
        term = ((mode_r == MODE_IDENT) && !is_ident(text_byte)) ||
               ((mode_r == MODE_NUMBER) && !is_digit(text_byte));
        cand_v[0] = term;
        cand[0]   = finish_tok(mode_r, hits_r, kwcnt_r, tstart_r, tline_r, tcol_r, off_r);
        mode_mid  = term ? MODE_IDLE : mode_r;

        case (mode_mid)
          MODE_STRING: begin
            if (text_byte == quote_c) begin
              cand_v[1]   = 1'b1;
              cand[1].kind  = KIND_STRING;
              cand[1].start = TOK_W'(tstart_r);
              cand[1].len   = TOK_W'(off_r - tstart_r);
              cand[1].line  = TOK_W'(tline_r);
              cand[1].col   = TOK_W'(tcol_r);
              mode_nxt    = MODE_IDLE;
            end
          end
          MODE_IDENT: begin
            hits_nxt  = kw_update(hits_r, kwcnt_r, text_byte);
            kwcnt_nxt = (kwcnt_r == '1) ? kwcnt_r : kwcnt_r + 1'b1;
          end
          MODE_NUMBER: begin
            mode_nxt = MODE_NUMBER;
          end
          default: begin
            mode_nxt = MODE_IDLE;
            if (is_blank(text_byte)) begin
              mode_nxt = MODE_IDLE;
            end else if (is_alpha(text_byte) || (text_byte == 8'h5F)) begin
              mode_nxt   = MODE_IDENT;
              tstart_nxt = off_r;
              tline_nxt  = line_r;
              tcol_nxt   = col_r;
              hits_nxt   = kw_update('1, '0, text_byte);
              kwcnt_nxt  = KW_CNT_W'(1);
            end else if (is_digit(text_byte)) begin
              mode_nxt   = MODE_NUMBER;
              tstart_nxt = off_r;
              tline_nxt  = line_r;
              tcol_nxt   = col_r;
            end else if ((text_byte == 8'h22) || (text_byte == 8'h27)) begin
              mode_nxt      = MODE_STRING;
              tstart_nxt    = off_r + 1'b1;
              tline_nxt     = line_r;
              tcol_nxt      = col_r;
              quote_dbl_nxt = (text_byte == 8'h22);
            end else if (punct_kind(text_byte) != '0) begin
              cand_v[1]     = 1'b1;
              cand[1].kind  = punct_kind(text_byte);
              cand[1].start = TOK_W'(off_r);
              cand[1].len   = TOK_W'(1);
              cand[1].line  = TOK_W'(line_r);
              cand[1].col   = TOK_W'(col_r);
            end
          end
        endcase

        off_nxt = off_r + 1'b1;
        if (text_byte == 8'h0A) begin
          line_nxt = line_r + 1'b1;
          col_nxt  = POS_W'(1);
        end else begin
          col_nxt = col_r + 1'b1;
        end

        if (is_final) begin
          cand_v[2] = (mode_nxt != MODE_IDLE);
          cand[2]   = finish_tok(mode_nxt, hits_nxt, kwcnt_nxt, tstart_nxt, tline_nxt,
                                 tcol_nxt, off_nxt);
          cand_v[3] = 1'b1;
          cand[3]   = end_tok(off_nxt, line_nxt, col_nxt);
          mode_nxt  = MODE_IDLE;
          ended_nxt = 1'b1;
        end
      end
    end

    // pack the candidates in order, at most three per byte
    n    = '0;
    slot = '0;
    for (int j = 0; j < 4; j++) begin
      if (cand_v[j]) begin
        if (n < 2'd3) begin
          slot[n] = cand[j];
        end
        n = n + 1'b1;
      end
    end

    // token limit
    room = LIM_W'(TOKEN_LIMIT) - LIM_W'(emitted_r);
    take = (room < LIM_W'(n)) ? room[1:0] : n;
    emitted_nxt = emitted_r + CNT_W'(take);
  end

  assign bnd_vld   = (take != '0);
  assign bnd.count = take;
  assign bnd.slot  = slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      quote_dbl_r <= 1'b0;
      off_r       <= '0;
      line_r      <= POS_W'(1);
      col_r       <= POS_W'(1);
      tstart_r    <= '0;
      tline_r     <= POS_W'(1);
      tcol_r      <= POS_W'(1);
      hits_r      <= '1;
      kwcnt_r     <= '0;
      emitted_r   <= '0;
      ended_r     <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      quote_dbl_r <= quote_dbl_nxt;
      off_r       <= off_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      tstart_r    <= tstart_nxt;
      tline_r     <= tline_nxt;
      tcol_r      <= tcol_nxt;
      hits_r      <= hits_nxt;
      kwcnt_r     <= kwcnt_nxt;
      emitted_r   <= emitted_nxt;
      ended_r     <= ended_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/klx_fifo.sv
`default_nettype none

module klx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = klx_pkg::KLX_FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/klx_back.sv
`default_nettype none

module klx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire klx_pkg::bundle_t  q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output klx_pkg::tok_t          tok,
  output logic                   run_end
);

  import klx_pkg::*;

  bundle_t    cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       last, advance, load;

  assign last    = (idx_r == cur_r.count - 1'b1);
  assign advance = pop && cur_vld_r;
  // refill when no word is held or as the last token of the held word leaves
  assign load    = !q_empty && (!cur_vld_r || (advance && last));
  assign q_pop   = load;

  assign empty   = !cur_vld_r;
  assign tok     = cur_r.slot[idx_r];
  assign run_end = last;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (load) begin
      cur_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (advance && last) begin
      cur_vld_r <= 1'b0;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/klx_checker.sv
`default_nettype none

module klx_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        full,
  input  wire logic                        empty,
  input  wire logic                        pop,
  input  wire logic [klx_pkg::KIND_W-1:0]  out_token_kind,
  input  wire logic [klx_pkg::TOK_W-1:0]   out_token_start,
  input  wire logic [klx_pkg::TOK_W-1:0]   out_token_length,
  input  wire logic                        out_run_end
);

  import klx_pkg::*;

  // nothing waits and input is open right after reset
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue not clear after reset");

  // a waiting token holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_token_kind) && $stable(out_token_start)))
    else $error("waiting token changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_token_kind <= KIND_END))
    else $error("token kind out of range");

  // end of input is always the last token of its byte and has no text
  a_end_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_token_kind == KIND_END)) |-> (out_run_end && (out_token_length == '0)))
    else $error("bad end token");

  a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_token_kind >= KIND_COMMA) && (out_token_kind <= KIND_MINUS))
      |-> (out_token_length == TOK_W'(1)))
    else $error("punctuation length not one");

endmodule

bind keyword_lexer_stream klx_checker u_klx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_token_kind   (out_token_kind),
  .out_token_start  (out_token_start),
  .out_token_length (out_token_length),
  .out_run_end      (out_run_end)
);

`default_nettype wire
